>>> rtl/assert_macros.svh
// assertion macros for the allocator
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/nfba_pkg.sv
// ----------------------------------------------------------------------------
// nfba_pkg
// types and constants shared by the allocator modules
// ----------------------------------------------------------------------------
package nfba_pkg;

  localparam int POOL_DEPTH = 1024;
  localparam int WORD_W     = 32;
  localparam int NWORDS     = POOL_DEPTH / WORD_W;
  localparam int POS_W      = $clog2(POOL_DEPTH);
  localparam int SIZE_W     = POS_W + 1;
  localparam int WADDR_W    = $clog2(NWORDS);
  localparam int BIT_W      = $clog2(WORD_W);
  localparam int CNT_W      = 11;

  localparam logic [0:0] CFG_BASE_INDEX = 1'b0;
  localparam logic [0:0] CFG_POOL_SIZE  = 1'b1;

  typedef enum logic [1:0] {
    CMD_ALLOC_ONE = 2'd0,
    CMD_FREE_ONE  = 2'd1,
    CMD_ALLOC_RUN = 2'd2,
    CMD_FREE_RUN  = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t        command;
    logic [31:0] index;
    logic [10:0] count;
  } in_req_t;

  typedef struct packed {
    logic        status;
    logic [31:0] alloc_index;
  } out_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MARK,
    ST_FREE,
    ST_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan_step;
    logic wrap;
    logic mark_step;
    logic free_step;
    logic finish;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_alloc;
    logic precheck_fail;
    logic found;
    logic scan_end;
    logic wrapped;
    logic mark_end;
    logic free_end;
  } dp_sts_t;

endpackage

>>> rtl/nfba_ctrl.sv
// ----------------------------------------------------------------------------
// nfba_ctrl
// request sequencing: scan, wrap, mark or free, then hand off the response
// ----------------------------------------------------------------------------
module nfba_ctrl
  import nfba_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    req_valid,
  output logic    req_ready,
  input  logic    rsp_free,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (req_valid) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (!sts.is_alloc) state_nxt = ST_FREE;
        else if (sts.precheck_fail) state_nxt = ST_DONE;
        else if (sts.found) state_nxt = ST_MARK;
        else if (sts.scan_end && sts.wrapped) state_nxt = ST_DONE;
      end
      ST_MARK: begin
        if (sts.mark_end) state_nxt = ST_DONE;
      end
      ST_FREE: begin
        if (sts.free_end) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (rsp_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    req_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        req_ready = 1'b1;
        cmd.load  = req_valid;
      end
      ST_SCAN: begin
        if (sts.is_alloc && !sts.precheck_fail) begin
          cmd.scan_step = !sts.scan_end;
          cmd.wrap      = sts.scan_end && !sts.wrapped && !sts.found;
        end
      end
      ST_MARK: cmd.mark_step = 1'b1;
      ST_FREE: cmd.free_step = 1'b1;
      ST_DONE: cmd.finish    = rsp_free;
      default: ;
    endcase
  end

endmodule

>>> rtl/nfba_dp.sv
// ----------------------------------------------------------------------------
// nfba_dp
// bitmap memory (one 32-bit word per cycle), run scanner and result register
// ----------------------------------------------------------------------------
module nfba_dp
  import nfba_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_sel,
  input  logic [31:0] cfg_data,
  input  in_req_t     req,
  input  dp_cmd_t     cmd,
  output dp_sts_t     sts,
  output logic        clr_busy,
  output out_rsp_t    rsp
);

  `include "assert_macros.svh"

  logic [WORD_W-1:0]  mem [NWORDS];
  logic [31:0]        base_r;
  logic [CNT_W-1:0]   psize_r;
  logic [SIZE_W-1:0]  start_r, start_nxt;
  logic               clr_r;
  logic [WADDR_W:0]   clr_cnt_r;

  cmd_t               op_r;
  logic [SIZE_W-1:0]  size_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [SIZE_W-1:0]  pos_r;      // scan, mark and free position
  logic               wrapped_r;
  logic [CNT_W-1:0]   run_r;
  logic [SIZE_W-1:0]  found_r;
  logic               found_r_v;
  logic [32:0]        fidx_r;     // free position, may exceed pool
  logic [CNT_W-1:0]   left_r;
  logic               pre_fail_r;
  logic [WORD_W-1:0]  word_r;
  logic               word_ok_r;
  out_rsp_t           rsp_r;

  logic [WADDR_W-1:0] raddr;
  logic [SIZE_W-1:0]  eff;

  assign eff = (psize_r > CNT_W'(POOL_DEPTH)) ? SIZE_W'(POOL_DEPTH) : SIZE_W'(psize_r);

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= '0;
      psize_r <= CNT_W'(POOL_DEPTH);
    end else if (cfg_we) begin
      if (cfg_sel == CFG_BASE_INDEX) base_r <= cfg_data;
      else psize_r <= cfg_data[CNT_W-1:0];
    end
  end

  // clearing pass after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= 1'b1;
      clr_cnt_r <= '0;
    end else if (clr_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == (WADDR_W+1)'(NWORDS - 1)) clr_r <= 1'b0;
    end
  end
  assign clr_busy = clr_r;

  // a single-alloc scan step tests the word at pos_r from pos_r up to the
  // word end or size; run scanning walks bits one per cycle inside the word
  // while held; for narrow logic a run step handles one bit, reading words once
  logic [WADDR_W-1:0] waddr;
  logic [BIT_W-1:0]   wbit;
  assign waddr = pos_r[POS_W-1:BIT_W];
  assign wbit  = pos_r[BIT_W-1:0];

  // word fetch: word_r holds the word for waddr when word_ok_r
  assign raddr = waddr;

  logic bit_used;
  assign bit_used = word_r[wbit];

  // single allocation: find first free bit at or above wbit in the word
  logic [WORD_W-1:0] free_mask;
  logic              any_free;
  logic [BIT_W-1:0]  first_free;
  always_comb begin
    free_mask  = ~word_r & ({WORD_W{1'b1}} << wbit);
    any_free   = |free_mask;
    first_free = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (free_mask[b]) first_free = BIT_W'(b);
    end
  end

  logic [SIZE_W-1:0] cand;
  assign cand = {pos_r[SIZE_W-1:BIT_W], first_free};

  logic [SIZE_W-1:0] next_word_pos;
  assign next_word_pos = {pos_r[SIZE_W-1:BIT_W] + 1'b1, {BIT_W{1'b0}}};

  logic scan_end;
  assign scan_end = (pos_r >= size_r);

  logic found_now;
  logic run_hit;
  assign run_hit = !bit_used && (run_r + 1'b1 == cnt_r);
  always_comb begin
    if (op_r == CMD_ALLOC_ONE) begin
      found_now = word_ok_r && !scan_end && any_free && (cand < size_r);
    end else begin
      found_now = word_ok_r && !scan_end && run_hit;
    end
  end

  logic [32:0] rel_free;
  assign rel_free = {1'b0, req.index - base_r};

  always_comb begin
    start_nxt = start_r;
    if (cmd.mark_step && op_r == CMD_ALLOC_ONE) start_nxt = found_r;
    else if (cmd.mark_step && left_r == CNT_W'(1)) start_nxt = pos_r + 1'b1;
  end

  logic left_r_zero;
  logic fidx_in;
  assign left_r_zero = (left_r == '0);
  assign fidx_in = (fidx_r < {22'b0, size_r});

  // mark and free walk one bit a cycle while word_ok_r, read-modify-writing word_r
  logic wr_en;
  logic [WADDR_W-1:0] wr_addr;
  logic [WORD_W-1:0]  wr_data;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = waddr;
    wr_data = word_r;
    if (clr_r) begin
      wr_en   = 1'b1;
      wr_addr = clr_cnt_r[WADDR_W-1:0];
      wr_data = '0;
    end else if (cmd.mark_step && word_ok_r) begin
      wr_en = 1'b1;
      wr_data[wbit] = 1'b1;
    end else if (cmd.free_step && word_ok_r && !left_r_zero) begin
      wr_en = fidx_in;
      wr_data[wbit] = 1'b0;
    end
  end

  logic [WORD_W-1:0] rd_data;
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[raddr];
  end

  logic              next_adv;
  logic [SIZE_W-1:0] adv_pos;

  always_comb begin
    next_adv = 1'b0;
    adv_pos  = pos_r;
    if (cmd.wrap) begin
      next_adv = 1'b1;
      adv_pos  = '0;
    end else if (cmd.scan_step && found_now) begin
      next_adv = 1'b1;
      adv_pos  = (op_r == CMD_ALLOC_ONE) ? cand : pos_r + 1'b1 - SIZE_W'(cnt_r);
    end else if (cmd.scan_step && word_ok_r) begin
      next_adv = 1'b1;
      adv_pos  = (op_r == CMD_ALLOC_ONE) ? next_word_pos : pos_r + 1'b1;
    end else if (cmd.mark_step && word_ok_r) begin
      next_adv = 1'b1;
      adv_pos  = pos_r + 1'b1;
    end else if (cmd.free_step && word_ok_r && !left_r_zero) begin
      next_adv = 1'b1;
      adv_pos  = pos_r + 1'b1;
    end
  end

  // word_r tracks memory contents for the current word; each change of word
  // address drops word_ok_r until fetch_r and the rd_data load refill word_r
  logic fetch_r;
  logic [WADDR_W-1:0] fetch_addr_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fetch_r   <= 1'b0;
      word_ok_r <= 1'b0;
    end else begin
      fetch_r <= !word_ok_r && !fetch_r && !cmd.load;
      if (!word_ok_r && !fetch_r && !cmd.load) fetch_addr_r <= waddr;
      if (cmd.load) begin
        word_ok_r <= 1'b0;
      end else if (fetch_r && fetch_addr_r == waddr) begin
        word_ok_r <= 1'b1;
        word_r    <= rd_data;
      end else begin
        if (wr_en && !clr_r) word_r <= wr_data;
        if (word_ok_r && next_adv && adv_pos[POS_W-1:BIT_W] != waddr) word_ok_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= '0;
      rsp_r   <= '0;
    end else begin
      start_r <= start_nxt;
      if (cmd.load) begin
        op_r       <= req.command;
        size_r     <= eff;
        cnt_r      <= req.count;
        run_r      <= '0;
        wrapped_r  <= 1'b0;
        found_r_v  <= 1'b0;
        pre_fail_r <= (req.command == CMD_ALLOC_RUN) &&
                      (req.count == '0 || {1'b0, req.count} > {1'b0, eff});
        if (req.command == CMD_FREE_ONE || req.command == CMD_FREE_RUN) begin
          fidx_r <= rel_free;
          left_r <= (req.command == CMD_FREE_ONE) ? CNT_W'(1) : req.count;
          pos_r  <= (rel_free < {22'b0, eff}) ? rel_free[SIZE_W-1:0] : '0;
        end else begin
          pos_r  <= start_r;
        end
      end else begin
        if (next_adv) pos_r <= adv_pos;
        if (cmd.wrap) begin
          wrapped_r <= 1'b1;
          run_r     <= '0;
        end
        if (cmd.scan_step && word_ok_r && op_r != CMD_ALLOC_ONE) begin
          run_r <= bit_used ? '0 : run_r + 1'b1;
        end
        if (cmd.scan_step && found_now) begin
          found_r_v <= 1'b1;
          if (op_r == CMD_ALLOC_ONE) begin
            found_r <= cand;
            left_r  <= CNT_W'(1);
          end else begin
            found_r <= pos_r + 1'b1 - SIZE_W'(cnt_r);
            left_r  <= cnt_r;
          end
        end
        if (cmd.mark_step && word_ok_r) left_r <= left_r - 1'b1;
        if (cmd.free_step && word_ok_r && !left_r_zero) begin
          left_r <= left_r - 1'b1;
          fidx_r <= fidx_r + 1'b1;
        end
        if (sts.mark_end || sts.free_end || (sts.precheck_fail && sts.is_alloc) ||
            (cmd.scan_step == 1'b0 && cmd.wrap == 1'b0 && sts.scan_end &&
             sts.wrapped && sts.is_alloc && !found_r_v && !sts.found &&
             !cmd.mark_step && !cmd.free_step && !cmd.finish)) begin
          rsp_r.status      <= sts.is_alloc && !found_r_v;
          rsp_r.alloc_index <= (sts.is_alloc && found_r_v) ? base_r + 32'(found_r) : '0;
        end
      end
    end
  end

  assign sts.is_alloc      = (op_r == CMD_ALLOC_ONE) || (op_r == CMD_ALLOC_RUN);
  assign sts.precheck_fail = pre_fail_r;
  assign sts.found         = found_r_v || found_now;
  assign sts.scan_end      = scan_end;
  assign sts.wrapped       = wrapped_r;
  assign sts.mark_end      = cmd.mark_step && word_ok_r && left_r == CNT_W'(1);
  assign sts.free_end      = cmd.free_step && (left_r_zero ||
                             (word_ok_r && left_r == CNT_W'(1)));
  assign rsp = rsp_r;

  `ASSERT_IMPL(a_mark_in_pool, cmd.mark_step && word_ok_r, pos_r < size_r,
    "mark outside pool")
  `ASSERT_IMPL(a_no_clear_busy, cmd.load, !clr_r, "request during clear")
  `ASSERT_NEXT(a_start_in_range, cmd.mark_step, start_r <= SIZE_W'(POOL_DEPTH),
    "search start out of range")

endmodule

>>> rtl/next_fit_bitmap_index_allocator_core.sv
// ----------------------------------------------------------------------------
// next_fit_bitmap_index_allocator_core
// next-fit index allocator over a bitmap of up to 1024 entries
// ----------------------------------------------------------------------------
// usage:
//   in_valid/in_ready carry one request (command, index, count); out_valid/
//   out_ready return one response (status, alloc_index) per request.
//   cfg_we with cfg_index 0 writes base_index, 1 writes pool_size; write only
//   while no request is outstanding.
// operation:
//   requests are handled one at a time. the bitmap sits in a 32-bit wide
//   memory; each word is fetched into a register before it is tested. a single
//   allocation tests a whole word per step, wrapping to the start once. a run
//   allocation tests one bit per cycle and then marks one bit per cycle, and a
//   free clears one bit per cycle, each while the current word is held.
// reset:
//   a clearing pass zeroes the bitmap word by word; in_ready stays low
//   meanwhile. config is taken at any time.
// stall:
//   the response is held in an output register until out_ready; the next
//   request is taken once it has been delivered.
module next_fit_bitmap_index_allocator_core
  import nfba_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_req_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_rsp_t    out_data,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  dp_cmd_t  cmd;
  dp_sts_t  sts;
  logic     clr_busy;
  logic     ctl_ready;
  logic     ov_r;

  nfba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_valid && !clr_busy && !ov_r),
    .req_ready (ctl_ready),
    .rsp_free  (!ov_r),
    .sts       (sts),
    .cmd       (cmd)
  );

  nfba_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_sel  (cfg_index),
    .cfg_data (cfg_data),
    .req      (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .clr_busy (clr_busy),
    .rsp      (out_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (cmd.finish) begin
      ov_r <= 1'b1;
    end else if (out_ready) begin
      ov_r <= 1'b0;
    end
  end

  assign in_ready  = ctl_ready && !clr_busy && !ov_r;
  assign out_valid = ov_r;

endmodule
